FILE: hdl/spq_pkg.sv
// Shared types and codes for the sorted priority queue.
// Used by spq_cell and sorted_priority_queue; depends on nothing.
package spq_pkg;

  localparam int DataW       = 32;
  localparam int ModeW       = 2;
  localparam int StatusW     = 2;
  localparam int OccW        = 5;
  localparam int DepthDefault = 16;

  localparam logic [ModeW-1:0] MODE_PUSH = 2'd0;
  localparam logic [ModeW-1:0] MODE_POP  = 2'd1;
  localparam logic [ModeW-1:0] MODE_PEEK = 2'd2;

  localparam logic [StatusW-1:0] ST_OK    = 2'd0;
  localparam logic [StatusW-1:0] ST_EMPTY = 2'd1;
  localparam logic [StatusW-1:0] ST_FULL  = 2'd2;

  // Broadcast to every cell in the row.
  typedef struct packed {
    logic                    ins_en;
    logic signed [DataW-1:0] ins_value;
  } spq_cmd_t;

endpackage

FILE: hdl/spq_cell.sv
// One slot of the sorted row: holds an entry, compares it with the
// value being pushed and takes the new value or its left neighbor's entry.
// Depends on spq_pkg.
module spq_cell
  import spq_pkg::*;
(
  input  logic                    clk,
  input  spq_cmd_t                cmd,
  input  logic                    occupied,
  input  logic                    is_rear,
  input  logic signed [DataW-1:0] left_value,
  input  logic                    left_greater,
  output logic signed [DataW-1:0] value,
  output logic                    greater,
  output logic [DataW-1:0]        rear_value
);

  logic signed [DataW-1:0] value_r;
  logic signed [DataW-1:0] value_nxt;

  assign value      = value_r;
  assign greater    = occupied && (value_r > cmd.ins_value);
  assign rear_value = is_rear ? value_r : '0;

  always_comb begin
    value_nxt = value_r;
    // Cells ahead of the insert point hold; the insert point takes the new
    // value and every cell behind it takes its neighbor's entry.
    if (cmd.ins_en && !greater) begin
      value_nxt = left_greater ? cmd.ins_value : left_value;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

FILE: hdl/sorted_priority_queue.sv
// Sorted priority queue built as a row of compare-and-shift cells.
// Depends on spq_pkg and spq_cell.
//
// Holds up to DEPTH signed 32-bit values in descending order; pop and peek
// return the smallest. busy stays low, a new item may be started in every
// cycle, and its result appears on the out_ ports with out_valid for
// exactly one cycle, the cycle after start.
// The result must be taken in that cycle; the block cannot be stalled.
// Push compares the new value against all cells at once and each cell
// shifts from its neighbor.
// No clearing pass is needed after reset.
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int DEPTH = DepthDefault
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [ModeW-1:0]          in_mode,
  input  logic signed [DataW-1:0]   in_value_in,
  output logic                      out_valid,
  output logic signed [DataW-1:0]   out_value_out,
  output logic [StatusW-1:0]        out_status,
  output logic [OccW-1:0]           out_occupancy
);

  localparam int CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0] count_r, count_nxt;
  logic            out_valid_r;
  logic signed [DataW-1:0] out_value_r, out_value_nxt;
  logic [StatusW-1:0] out_status_r, out_status_nxt;
  logic [OccW-1:0]    out_occ_r;

  logic     accept, is_push, is_read, full, empty;
  spq_cmd_t cmd;

  logic                    occ     [DEPTH+1];
  logic signed [DataW-1:0] cell_val [DEPTH];
  logic                    cell_gt [DEPTH];
  logic [DataW-1:0]        cell_rear [DEPTH];
  logic [DataW-1:0]        rear_value;

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign is_push = (in_mode == MODE_PUSH);
  assign is_read = (in_mode == MODE_POP) || (in_mode == MODE_PEEK);
  assign full    = (count_r == CntW'(DEPTH));
  assign empty   = (count_r == '0);

  assign cmd.ins_en    = accept && is_push && !full;
  assign cmd.ins_value = in_value_in;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      occ[i] = (CntW'(i) < count_r);
    end
    occ[DEPTH] = 1'b0;
  end

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      spq_cell u_cell (
        .clk          (clk),
        .cmd          (cmd),
        .occupied     (occ[g]),
        .is_rear      (occ[g] && !occ[g+1]),
        .left_value   ((g == 0) ? cmd.ins_value : cell_val[(g == 0) ? 0 : g-1]),
        .left_greater ((g == 0) ? 1'b1 : cell_gt[(g == 0) ? 0 : g-1]),
        .value        (cell_val[g]),
        .greater      (cell_gt[g]),
        .rear_value   (cell_rear[g])
      );
    end
  endgenerate

  // Only the rear cell drives a nonzero word.
  always_comb begin
    rear_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rear_value = rear_value | cell_rear[i];
    end
  end

  always_comb begin
    count_nxt      = count_r;
    out_value_nxt  = '0;
    out_status_nxt = ST_OK;
    if (is_push) begin
      if (full) begin
        out_status_nxt = ST_FULL;
      end else begin
        count_nxt = count_r + 1'b1;
      end
    end else if (is_read) begin
      if (empty) begin
        out_status_nxt = ST_EMPTY;
      end else begin
        out_value_nxt = rear_value;
        if (in_mode == MODE_POP) begin
          count_nxt = count_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
    if (accept) begin
      out_value_r  <= out_value_nxt;
      out_status_r <= out_status_nxt;
      out_occ_r    <= OccW'(count_nxt);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_value_out = out_value_r;
  assign out_status    = out_status_r;
  assign out_occupancy = out_occ_r;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted item produced no result");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(DEPTH))
    else $error("entry count above depth");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_FULL) |-> full)
    else $error("full status while queue not full");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_mode == MODE_POP && !empty) |=> (count_r == $past(count_r) - 1'b1))
    else $error("pop did not remove an entry");

  a_rear_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_OK && out_value_r != '0) |->
      (out_value_r == $past(rear_value)))
    else $error("returned value is not the rear entry");

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking bench for sorted_priority_queue: push, pop, peek and the unused mode.
// A software copy of the sorted store predicts every result. Depends on spq_pkg.
module tb_top;
  import spq_pkg::*;

  localparam int Depth = DepthDefault;
  localparam logic [ModeW-1:0] MODE_IDLE = 2'd3;
  localparam int RandomOps = 1900;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_t;

  typedef struct {
    logic [ModeW-1:0]        mode;
    logic signed [DataW-1:0] value;
    logic                    wait_empty;
  } op_item_t;

  typedef struct {
    logic signed [DataW-1:0] value;
    logic [StatusW-1:0]      status;
    logic [OccW-1:0]         occ;
  } pq_result_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [ModeW-1:0]        in_mode = MODE_IDLE;
  logic signed [DataW-1:0] in_value_in = '0;
  logic                    out_valid;
  logic signed [DataW-1:0] out_value_out;
  logic [StatusW-1:0]      out_status;
  logic [OccW-1:0]         out_occupancy;

  op_item_t   pending_ops[$];
  pq_result_t expected_results[$];
  int         n_issued = 0;
  int         n_done = 0;
  int         errors = 0;
  int         burst_left = 0;
  int         gap_left = 0;

  // Sorted copy of the queue contents: slot 0 largest, rear smallest.
  logic signed [DataW-1:0] sorted_slots[Depth];
  int                      held = 0;

  sorted_priority_queue #(.DEPTH(Depth)) DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_mode      (in_mode),
    .in_value_in  (in_value_in),
    .out_valid    (out_valid),
    .out_value_out(out_value_out),
    .out_status   (out_status),
    .out_occupancy(out_occupancy)
  );

  always #2 clk = ~clk;

  function automatic pq_result_t queue_apply(logic [ModeW-1:0] mode,
                                             logic signed [DataW-1:0] val);
    pq_result_t r;
    int pos;
    r.value = '0;
    r.status = ST_OK;
    case (mode)
      MODE_PUSH: begin
        if (held >= Depth) begin
          r.status = ST_FULL;
        end else begin
          pos = 0;
          // equal values go ahead of the ones already held
          while (pos < held && sorted_slots[pos] > val) pos++;
          for (int i = held; i > pos; i--) sorted_slots[i] = sorted_slots[i-1];
          sorted_slots[pos] = val;
          held++;
        end
      end
      MODE_POP, MODE_PEEK: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.value = sorted_slots[held-1];
          if (mode == MODE_POP) held--;
        end
      end
      default: ;
    endcase
    r.occ = held[OccW-1:0];
    return r;
  endfunction

  function automatic logic signed [DataW-1:0] rand_value();
    case ($urandom_range(0, 9))
      5, 6: return DataW'($signed($urandom_range(0, 16)) - 8);
      7: begin
        case ($urandom_range(0, 3))
          0: return 32'sh7FFFFFFF;
          1: return 32'sh80000000;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic add_op(logic [ModeW-1:0] mode, logic signed [DataW-1:0] val);
    op_item_t it;
    it.mode = mode;
    it.value = val;
    it.wait_empty = 1'b0;
    pending_ops.push_back(it);
  endtask

  task automatic add_pause();
    op_item_t it;
    it.mode = MODE_IDLE;
    it.value = '0;
    it.wait_empty = 1'b1;
    pending_ops.push_back(it);
  endtask

  // Driver: launch items in bursts, hold on busy, stop at pause markers
  // until all outstanding results are back.
  always @(posedge clk) begin : drive
    op_item_t nxt;
    if (!rst_n) begin
      start <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (start && !busy) begin
        expected_results.push_back(queue_apply(in_mode, in_value_in));
        n_issued <= n_issued + 1;
      end
      if (start && busy) begin
        // hold the item until the block takes it
      end else if (gap_left != 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_ops.size() == 0) begin
        start <= 1'b0;
      end else if (pending_ops[0].wait_empty) begin
        start <= 1'b0;
        if (!start && n_issued == n_done) void'(pending_ops.pop_front());
      end else begin
        nxt = pending_ops.pop_front();
        start <= 1'b1;
        in_mode <= nxt.mode;
        in_value_in <= nxt.value;
        if (burst_left <= 1) begin
          burst_left <= ($urandom_range(0, 5) == 0) ? $urandom_range(100, 200)
                                                     : $urandom_range(1, 30);
          gap_left <= $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Monitor: every strobe must match the oldest prediction.
  always @(posedge clk) begin : monitor
    pq_result_t want;
    if (rst_n && out_valid) begin
      n_done <= n_done + 1;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result value=%0d status=%0d occupancy=%0d",
                 $time, out_value_out, out_status, out_occupancy);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (out_value_out !== want.value) begin
          $display("%0t: value_out expected %0d actual %0d", $time, want.value, out_value_out);
          errors++;
        end
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
          errors++;
        end
        if (out_occupancy !== want.occ) begin
          $display("%0t: occupancy expected %0d actual %0d", $time, want.occ, out_occupancy);
          errors++;
        end
      end
    end
  end

  initial begin : stimulus
    phase_t kind;
    int     n_rand;
    int     len;
    int     pick;
    bit     paused;
    // empty queue, extremes, ties, the unused mode
    add_op(MODE_POP, 32'sh12345678);
    add_op(MODE_PEEK, '1);
    add_op(MODE_IDLE, 32'sh55AA55AA);
    add_op(MODE_PUSH, 32'sh7FFFFFFF);
    add_op(MODE_PUSH, 32'sh80000000);
    add_op(MODE_PUSH, '0);
    add_op(MODE_PUSH, '1);
    add_op(MODE_PUSH, '0);
    add_op(MODE_PEEK, '0);
    add_op(MODE_POP, '0);
    add_op(MODE_IDLE, '0);
    // fill to capacity, then push into a full queue
    repeat (12) add_op(MODE_PUSH, rand_value());
    add_op(MODE_PUSH, 32'sh0000_0001);
    add_op(MODE_PEEK, '0);
    add_pause();

    n_rand = 0;
    paused = 1'b0;
    while (n_rand < RandomOps) begin
      kind = phase_t'($urandom_range(0, 2));
      len = $urandom_range(15, 70);
      repeat (len) begin
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
          add_op(MODE_IDLE, rand_value());
        end else begin
          case (kind)
            PH_FILL:  pick = (pick < 75) ? 0 : (pick < 90) ? 1 : 2;
            PH_DRAIN: pick = (pick < 20) ? 0 : (pick < 80) ? 1 : 2;
            default:  pick = (pick < 45) ? 0 : (pick < 80) ? 1 : 2;
          endcase
          case (pick)
            0: add_op(MODE_PUSH, rand_value());
            1: add_op(MODE_POP, rand_value());
            default: add_op(MODE_PEEK, rand_value());
          endcase
          n_rand++;
        end
      end
      if (!paused && n_rand >= RandomOps / 2) begin
        add_pause();
        paused = 1'b1;
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // sample at the falling edge so every update of the rising edge has settled
    do @(negedge clk);
    while (pending_ops.size() != 0 || start || n_issued != n_done);
    repeat (10) @(negedge clk);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
